// File: src/pnq_pkg.sv
`timescale 1ns / 1ps
package pnq_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 16;

   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;
   localparam int CHAN_W  = 8;
   localparam int DIST_W  = 10;
   localparam int COLOR_W = 3 * CHAN_W;

   // Largest Manhattan distance over three 8-bit channels.
   localparam int DIST_MAX = 3 * ((1 << CHAN_W) - 1);

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// File: src/pnq_ifs.sv
`timescale 1ns / 1ps
interface pnq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [pnq_pkg::INDEX_W-1:0]   entry_index;
   logic [pnq_pkg::CHAN_W-1:0]    pixel_red;
   logic [pnq_pkg::CHAN_W-1:0]    pixel_green;
   logic [pnq_pkg::CHAN_W-1:0]    pixel_blue;
   logic [pnq_pkg::CHAN_W-1:0]    pixel_alpha;

   modport source (output valid, req_type, entry_index, pixel_red, pixel_green,
                   pixel_blue, pixel_alpha, input ready);
   modport sink (input valid, req_type, entry_index, pixel_red, pixel_green,
                 pixel_blue, pixel_alpha, output ready);
endinterface

interface pnq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pnq_pkg::CHAN_W-1:0]    out_red;
   logic [pnq_pkg::CHAN_W-1:0]    out_green;
   logic [pnq_pkg::CHAN_W-1:0]    out_blue;
   logic [pnq_pkg::CHAN_W-1:0]    out_alpha;
   logic [pnq_pkg::INDEX_W-1:0]   chosen_entry;
   logic [pnq_pkg::DIST_W-1:0]    best_distance;

   modport source (output valid, out_red, out_green, out_blue, out_alpha,
                   chosen_entry, best_distance, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                 chosen_entry, best_distance, output ready);
endinterface

interface pnq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pnq_pkg::COUNT_W-1:0]   palette_count;

   modport source (output valid, palette_count, input ready);
   modport sink (input valid, palette_count, output ready);
endinterface

// File: src/pnq_ram.sv
`timescale 1ns / 1ps
module pnq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: src/palette_nearest_color_quantizer.sv
`timescale 1ns / 1ps
// Nearest-color quantizer: a write request stores a 24-bit RGB entry at entry_index; a pixel
// request scans palette entries 0 .. palette_count-1 (saturated to PALETTE_DEPTH) and returns
// the first entry at the smallest |dr|+|dg|+|db|, with the pixel's alpha passed through, or
// black at distance 0 when the count is zero. The palette sits in one single-port-read RAM
// read one entry per cycle, and a pixel occupies the block until its scan is done and its
// result is loaded into the output register. A finished result waits in the output register
// while the next request is accepted. Entries must be written before a pixel scans them.
module palette_nearest_color_quantizer #(
   parameter int PALETTE_DEPTH = pnq_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pnq_req_if.sink    req_bus,
   pnq_rsp_if.source  rsp_bus,
   pnq_csr_if.sink    csr_bus
);

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CW     = pnq_pkg::CHAN_W;

   pnq_pkg::state_type state_ff, state_in;

   logic [pnq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pnq_pkg::COUNT_W-1:0] sat_count;
   logic [pnq_pkg::COUNT_W-1:0] scan_idx_ff, scan_idx_in;

   logic                        tag_vld_ff, tag_vld_in;
   logic [pnq_pkg::INDEX_W-1:0] tag_idx_ff, tag_idx_in;

   logic [CW-1:0] pix_red_ff, pix_green_ff, pix_blue_ff, pix_alpha_ff;

   logic                        have_ff, have_in;
   logic [pnq_pkg::DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [pnq_pkg::INDEX_W-1:0] best_idx_ff, best_idx_in;
   logic [pnq_pkg::COLOR_W-1:0] best_color_ff, best_color_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]               rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic [pnq_pkg::INDEX_W-1:0] rsp_entry_ff;
   logic [pnq_pkg::DIST_W-1:0]  rsp_dist_ff;

   logic                        req_take;
   logic                        take_pixel;
   logic                        scan_last;
   logic                        load_rsp;
   logic                        wr_en;
   logic                        rd_en;
   logic [pnq_pkg::COLOR_W-1:0] rd_data;
   logic [pnq_pkg::DIST_W-1:0]  cand_dist;
   logic                        better;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign req_bus.ready = (state_ff == pnq_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign take_pixel    = req_take && (req_bus.req_type == pnq_pkg::REQ_PIXEL);

   assign sat_count = (32'(count_ff) > PALETTE_DEPTH) ? pnq_pkg::COUNT_W'(PALETTE_DEPTH)
                                                      : count_ff;
   assign scan_last = (scan_idx_ff == (sat_count - pnq_pkg::COUNT_W'(1)));

   assign count_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.palette_count : count_ff;

   // Writes land in the request cycle, so a later pixel scan reads the stored entry.
   assign wr_en = req_take && (req_bus.req_type == pnq_pkg::REQ_WRITE)
                  && (32'(req_bus.entry_index) < PALETTE_DEPTH);
   assign rd_en = (state_ff == pnq_pkg::ST_SCAN);

   pnq_ram #(
      .WIDTH (pnq_pkg::COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_bus.entry_index)),
      .wr_data ({req_bus.pixel_red, req_bus.pixel_green, req_bus.pixel_blue}),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(scan_idx_ff)),
      .rd_data (rd_data)
   );

   assign cand_dist = pnq_pkg::DIST_W'(abs_diff(pix_red_ff, rd_data[3*CW-1:2*CW]))
                    + pnq_pkg::DIST_W'(abs_diff(pix_green_ff, rd_data[2*CW-1:CW]))
                    + pnq_pkg::DIST_W'(abs_diff(pix_blue_ff, rd_data[CW-1:0]));
   // Strict less-than keeps the lower index on a tie.
   assign better = tag_vld_ff && (!have_ff || (cand_dist < best_dist_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pnq_pkg::ST_IDLE: begin
            if (take_pixel) begin
               state_in = (sat_count == '0) ? pnq_pkg::ST_DONE : pnq_pkg::ST_SCAN;
            end
         end
         pnq_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = pnq_pkg::ST_DRAIN;
            end
         end
         pnq_pkg::ST_DRAIN: begin
            state_in = pnq_pkg::ST_DONE;
         end
         pnq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = pnq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pnq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      tag_vld_in    = 1'b0;
      tag_idx_in    = scan_idx_ff[pnq_pkg::INDEX_W-1:0];
      have_in       = have_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_color_in = best_color_ff;
      load_rsp      = 1'b0;
      case (state_ff)
         pnq_pkg::ST_IDLE: begin
            scan_idx_in = '0;
            if (take_pixel) begin
               have_in       = 1'b0;
               best_dist_in  = '0;
               best_idx_in   = '0;
               best_color_in = '0;
            end
         end
         pnq_pkg::ST_SCAN: begin
            scan_idx_in = scan_idx_ff + pnq_pkg::COUNT_W'(1);
            tag_vld_in  = 1'b1;
         end
         pnq_pkg::ST_DRAIN: begin
            scan_idx_in = '0;
         end
         pnq_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
            scan_idx_in = '0;
         end
      endcase
      if (better) begin
         have_in       = 1'b1;
         best_dist_in  = cand_dist;
         best_idx_in   = tag_idx_ff;
         best_color_in = rd_data;
      end
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnq_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         tag_vld_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         tag_vld_ff   <= tag_vld_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_idx_ff    <= tag_idx_in;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      best_color_ff <= best_color_in;
      if (take_pixel) begin
         pix_red_ff   <= req_bus.pixel_red;
         pix_green_ff <= req_bus.pixel_green;
         pix_blue_ff  <= req_bus.pixel_blue;
         pix_alpha_ff <= req_bus.pixel_alpha;
      end
      if (load_rsp) begin
         rsp_red_ff   <= best_color_ff[3*CW-1:2*CW];
         rsp_green_ff <= best_color_ff[2*CW-1:CW];
         rsp_blue_ff  <= best_color_ff[CW-1:0];
         rsp_alpha_ff <= pix_alpha_ff;
         rsp_entry_ff <= best_idx_ff;
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_red       = rsp_red_ff;
   assign rsp_bus.out_green     = rsp_green_ff;
   assign rsp_bus.out_blue      = rsp_blue_ff;
   assign rsp_bus.out_alpha     = rsp_alpha_ff;
   assign rsp_bus.chosen_entry  = rsp_entry_ff;
   assign rsp_bus.best_distance = rsp_dist_ff;

endmodule

// File: src/pnq_checker.sv
`timescale 1ns / 1ps
module pnq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_type,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pnq_pkg::CHAN_W-1:0]    out_red,
   input logic [pnq_pkg::CHAN_W-1:0]    out_green,
   input logic [pnq_pkg::CHAN_W-1:0]    out_blue,
   input logic [pnq_pkg::CHAN_W-1:0]    out_alpha,
   input logic [pnq_pkg::INDEX_W-1:0]   chosen_entry,
   input logic [pnq_pkg::DIST_W-1:0]    best_distance
);

   // A held response keeps its payload until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_red) && $stable(out_green)
         && $stable(out_blue) && $stable(out_alpha) && $stable(chosen_entry)
         && $stable(best_distance))
      else $error("response changed while stalled");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (best_distance <= 10'(pnq_pkg::DIST_MAX)))
      else $error("distance beyond three-channel maximum");

   // A palette write never produces a response of its own.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == pnq_pkg::REQ_WRITE) |=> !$rose(rsp_valid))
      else $error("response raised by a palette write");

   // A pixel response does not appear in the cycle after its request is taken.
   a_pixel_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == pnq_pkg::REQ_PIXEL) && !rsp_valid
      |=> !rsp_valid)
      else $error("response appeared in the cycle after the pixel request");

endmodule

bind palette_nearest_color_quantizer pnq_checker u_pnq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_type      (req_bus.req_type),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .out_red       (rsp_bus.out_red),
   .out_green     (rsp_bus.out_green),
   .out_blue      (rsp_bus.out_blue),
   .out_alpha     (rsp_bus.out_alpha),
   .chosen_entry  (rsp_bus.chosen_entry),
   .best_distance (rsp_bus.best_distance)
);

// File: test/pnq_nearest_checker.sv
`timescale 1ns / 1ps
module pnq_nearest_checker (
   input  logic clock,
   input  logic reset,
   pnq_req_if   req_bus,
   pnq_rsp_if   rsp_bus,
   pnq_csr_if   csr_bus,
   output int   mismatch_count,
   output int   results_owed
);

   localparam int DEPTH = pnq_pkg::PALETTE_DEPTH_DEFAULT;
   localparam int CW    = pnq_pkg::CHAN_W;

   typedef struct packed {
      logic [CW-1:0]               red;
      logic [CW-1:0]               green;
      logic [CW-1:0]               blue;
      logic [CW-1:0]               alpha;
      logic [pnq_pkg::INDEX_W-1:0] entry;
      logic [pnq_pkg::DIST_W-1:0]  distance;
   } quant_result_type;

   logic [pnq_pkg::COLOR_W-1:0] palette [DEPTH];
   logic [pnq_pkg::COUNT_W-1:0] entries_in_use;
   quant_result_type            expected_colors [$];

   function automatic int chan_gap(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return (x > y) ? int'(x - y) : int'(y - x);
   endfunction

   // The first entry at the smallest distance wins, so ties keep the lower index.
   function automatic quant_result_type nearest_color(input logic [CW-1:0] r,
                                                      input logic [CW-1:0] g,
                                                      input logic [CW-1:0] b,
                                                      input logic [CW-1:0] a);
      quant_result_type best;
      int               scan_len;
      int               d;
      best = '0;
      best.alpha = a;
      scan_len = (int'(entries_in_use) > DEPTH) ? DEPTH : int'(entries_in_use);
      for (int k = 0; k < scan_len; k++) begin
         d = chan_gap(r, palette[k][2*CW +: CW])
           + chan_gap(g, palette[k][CW +: CW])
           + chan_gap(b, palette[k][0 +: CW]);
         if (k == 0 || d < int'(best.distance)) begin
            best.red      = palette[k][2*CW +: CW];
            best.green    = palette[k][CW +: CW];
            best.blue     = palette[k][0 +: CW];
            best.entry    = pnq_pkg::INDEX_W'(k);
            best.distance = pnq_pkg::DIST_W'(d);
         end
      end
      return best;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      quant_result_type want;
      if (reset) begin
         entries_in_use = '0;
         expected_colors.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_colors.size() == 0) begin
               $error("result arrived with no pixel request outstanding");
               mismatch_count++;
            end else begin
               want = expected_colors.pop_front();
               check_field("out_red", 16'(want.red), 16'(rsp_bus.out_red));
               check_field("out_green", 16'(want.green), 16'(rsp_bus.out_green));
               check_field("out_blue", 16'(want.blue), 16'(rsp_bus.out_blue));
               check_field("out_alpha", 16'(want.alpha), 16'(rsp_bus.out_alpha));
               check_field("chosen_entry", 16'(want.entry), 16'(rsp_bus.chosen_entry));
               check_field("best_distance", 16'(want.distance), 16'(rsp_bus.best_distance));
            end
         end
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            entries_in_use = csr_bus.palette_count;
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            if (req_bus.req_type == pnq_pkg::REQ_WRITE) begin
               if (int'(req_bus.entry_index) < DEPTH) begin
                  palette[req_bus.entry_index] = {req_bus.pixel_red, req_bus.pixel_green,
                                                  req_bus.pixel_blue};
               end
            end else begin
               expected_colors.push_back(nearest_color(req_bus.pixel_red, req_bus.pixel_green,
                                                       req_bus.pixel_blue,
                                                       req_bus.pixel_alpha));
            end
         end
      end
      results_owed = expected_colors.size();
   end

endmodule

// File: test/tb_palette_nearest_color_quantizer.sv
`timescale 1ns / 1ps
module tb_palette_nearest_color_quantizer;
   import pnq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_go;
   logic rsp_hold;
   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;
   int   mismatch_count;
   int   results_owed;

   pnq_req_if req_bus ();
   pnq_rsp_if rsp_bus ();
   pnq_csr_if csr_bus ();

   palette_nearest_color_quantizer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pnq_nearest_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // One long back-pressure stretch so the block fills up and stalls its input.
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go === 1'b1);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [CHAN_W-1:0] pick_chan();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // Valid stays high between back-to-back requests; here it drops only for idle cycles drawn against sender_idle_pct.
   task automatic send_request(input req_kind_type kind, input logic [INDEX_W-1:0] idx,
                               input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.entry_index <= idx;
      req_bus.pixel_red   <= r;
      req_bus.pixel_green <= g;
      req_bus.pixel_blue  <= b;
      req_bus.pixel_alpha <= a;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Palette writes return nothing, so allow the longest scan to finish after the last result.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_bus.valid         <= 1'b1;
      csr_bus.palette_count <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] count, input int idle_pct,
                            input int stall_pct, input int n_requests, input bit pressure);
      req_kind_type kind;
      settle();
      write_count(count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (pressure) begin
         hold_go <= 1'b1;
      end
      repeat (n_requests) begin
         kind = ($urandom_range(99) < 65) ? REQ_PIXEL : REQ_WRITE;
         send_request(kind, INDEX_W'($urandom_range(15)), pick_chan(), pick_chan(),
                      pick_chan(), CHAN_W'($urandom));
      end
   endtask

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_WRITE;
      req_bus.entry_index   <= '0;
      req_bus.pixel_red     <= '0;
      req_bus.pixel_green   <= '0;
      req_bus.pixel_blue    <= '0;
      req_bus.pixel_alpha   <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.palette_count <= '0;
      hold_go               <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The palette is empty after reset: black at distance zero, alpha still passed.
      send_request(REQ_PIXEL, 4'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(REQ_PIXEL, 4'hF, 8'h00, 8'h00, 8'h00, 8'h00);

      // Fill every entry before any pixel can scan it; entries 5 and 6 are equal.
      send_request(REQ_WRITE, 4'd0, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_request(REQ_WRITE, 4'd1, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_request(REQ_WRITE, 4'd2, 8'hFF, 8'h00, 8'h00, 8'h00);
      send_request(REQ_WRITE, 4'd3, 8'h00, 8'hFF, 8'h00, 8'h00);
      send_request(REQ_WRITE, 4'd4, 8'h00, 8'h00, 8'hFF, 8'h00);
      send_request(REQ_WRITE, 4'd5, 8'h80, 8'h80, 8'h80, 8'h00);
      send_request(REQ_WRITE, 4'd6, 8'h80, 8'h80, 8'h80, 8'h00);
      for (int k = 7; k < 16; k++) begin
         send_request(REQ_WRITE, INDEX_W'(k), pick_chan(), pick_chan(), pick_chan(), 8'h00);
      end
      settle();
      write_count(5'd16);
      send_request(REQ_PIXEL, 4'h0, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_request(REQ_PIXEL, 4'h0, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      send_request(REQ_PIXEL, 4'h0, 8'h80, 8'h80, 8'h80, 8'h5A);
      send_request(REQ_PIXEL, 4'h0, 8'h7F, 8'h7F, 8'h7F, 8'hA5);
      send_request(REQ_PIXEL, 4'h0, 8'hFF, 8'h00, 8'hFF, 8'h01);

      run_phase(5'd16, 0, 0, 250, 1'b0);
      run_phase(5'd1, 79, 0, 150, 1'b0);
      run_phase(5'd31, 0, 79, 200, 1'b0);
      run_phase(5'd0, 18, 18, 100, 1'b0);
      run_phase(COUNT_W'($urandom_range(15, 2)), 18, 18, 200, 1'b0);
      run_phase(5'd17, 0, 0, 150, 1'b1);
      run_phase(COUNT_W'($urandom_range(16, 1)), 0, 0, 250, 1'b0);
      settle();

      if (mismatch_count == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
